// ===== hdl/bts_pkg.sv =====
`timescale 1ns / 1ps

package bts_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIM_W     = 9;
  localparam int CH_W      = 8;
  localparam int OUT_W     = 16;
  localparam int TEXEL_W   = 3 * CH_W;
  localparam int WT_W      = 2 * FRAC_BITS + 1;
  localparam int MUL_A_W   = WT_W;
  localparam int MUL_B_W   = FRAC_BITS + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 2 * FRAC_BITS + CH_W;
  localparam int OUT_SHIFT = 2 * FRAC_BITS - 8;

  localparam logic [FRAC_BITS:0] FRAC_ONE   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) << (OUT_SHIFT - 1);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } bts_op_e;

  localparam logic CFG_HEIGHT = 1'b0;
  localparam logic CFG_WIDTH  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COORD,
    ST_FETCH,
    ST_BLEND
  } bts_state_e;

  typedef struct packed {
    bts_op_e                operation;
    logic [7:0]             row;
    logic [7:0]             column;
    logic [CH_W-1:0]        red_in;
    logic [CH_W-1:0]        green_in;
    logic [CH_W-1:0]        blue_in;
    logic [FRAC_BITS-1:0]   u_frac;
    logic [FRAC_BITS-1:0]   v_frac;
  } bts_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
  } bts_rsp_t;

endpackage

// ===== hdl/bilinear_texture_sampler_wrap.sv =====
`timescale 1ns / 1ps

// Channel        Direction  Handshake                     Payload
// request        in         start / busy                  req_i (bts_req_t)
// result         out        valid_o, one-cycle strobe     rsp_o (bts_rsp_t)
// configuration  in         cfg_we_i, cfg_idx_i           cfg_wdata_i
//
// A texel write leaves busy low and produces no result.
// A sample keeps busy high through the column coordinate, the four texel
// reads from the single-port store (the weights are formed in the same
// cycles), and the weighted sums for each channel, all through one shared
// multiplier. The result strobe follows, and a new transaction may start in
// that same cycle. The receiver cannot stall. Reset restores both dimension
// registers to 256; texel contents are undefined until written.

module bilinear_texture_sampler_wrap
  import bts_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bts_req_t         req_i,
  output logic             valid_o,
  output bts_rsp_t         rsp_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_wdata_i
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;

  bts_state_e state_q, state_d;
  logic [1:0] k_q, k_d;
  logic [1:0] ch_q, ch_d;

  logic [DIM_W-1:0] tex_height_q, tex_width_q;
  logic [DIM_W-1:0] height, width;

  logic [FRAC_BITS-1:0] v_q;
  logic [DIM_W-1:0]     r0_q, c0_q;
  logic [FRAC_BITS-1:0] fu_q, fv_q;
  logic [DIM_W-1:0]     r0_inc, c0_inc, r1, c1, r_sel, c_sel;

  logic [TEXEL_W-1:0] mem [DEPTH];
  logic [TEXEL_W-1:0] mem_rdata_q;
  logic [TEXEL_W-1:0] tex_q [4];
  logic               rd_pend_q;
  logic [1:0]         rd_idx_q;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic               mem_we, mem_re;

  logic [WT_W-1:0]    wt_q [4];
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc_q, acc_sum;
  logic [CH_W-1:0]    chan;
  logic [OUT_W-1:0]   red_q, green_q;
  bts_rsp_t           rsp_q;
  logic               valid_q, last_step;
  logic               accept;

  // A zero dimension acts as one, and a dimension beyond the store saturates.
  always_comb begin
    if (tex_height_q == '0) begin
      height = DIM_W'(1);
    end else if (32'(tex_height_q) > MAX_ROWS) begin
      height = DIM_W'(MAX_ROWS);
    end else begin
      height = tex_height_q;
    end
    if (tex_width_q == '0) begin
      width = DIM_W'(1);
    end else if (32'(tex_width_q) > MAX_COLS) begin
      width = DIM_W'(MAX_COLS);
    end else begin
      width = tex_width_q;
    end
  end

  assign accept = start && !busy;

  // Next state and sequencing counters.
  always_comb begin
    state_d = state_q;
    k_d     = '0;
    ch_d    = ch_q;
    case (state_q)
      ST_IDLE: begin
        ch_d = '0;
        if (start && req_i.operation == OP_SAMPLE) begin
          state_d = ST_COORD;
        end
      end
      ST_COORD: begin
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          ch_d = ch_q + 2'd1;
          if (ch_q == 2'd2) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: multiplier operands and memory controls.
  always_comb begin
    busy      = (state_q != ST_IDLE);
    mem_re    = (state_q == ST_FETCH);
    last_step = (state_q == ST_BLEND) && (ch_q == 2'd2) && (k_q == 2'd3);
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      ST_IDLE: begin
        mul_a = MUL_A_W'(req_i.u_frac);
        mul_b = MUL_B_W'(height);
      end
      ST_COORD: begin
        mul_a = MUL_A_W'(v_q);
        mul_b = MUL_B_W'(width);
      end
      ST_FETCH: begin
        mul_a = k_q[1] ? MUL_A_W'(fu_q) : MUL_A_W'(FRAC_ONE - {1'b0, fu_q});
        mul_b = k_q[0] ? MUL_B_W'(fv_q) : MUL_B_W'(FRAC_ONE - {1'b0, fv_q});
      end
      ST_BLEND: begin
        mul_a = wt_q[k_q];
        mul_b = MUL_B_W'(chan);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (ch_q)
      2'd0:    chan = tex_q[k_q][TEXEL_W-1 -: CH_W];
      2'd1:    chan = tex_q[k_q][2*CH_W-1 -: CH_W];
      default: chan = tex_q[k_q][CH_W-1:0];
    endcase
  end

  assign prod = mul_a * mul_b;

  // The rounding half is preloaded with the first term of each channel.
  assign acc_sum = ((k_q == 2'd0) ? ROUND_HALF : acc_q) + prod[ACC_W-1:0];

  // Neighbor addresses; the floor never reaches the dimension, so only the
  // second row and column need wrapping.
  assign r0_inc = r0_q + DIM_W'(1);
  assign c0_inc = c0_q + DIM_W'(1);
  assign r1     = (r0_inc >= height) ? '0 : r0_inc;
  assign c1     = (c0_inc >= width) ? '0 : c0_inc;
  assign r_sel  = k_q[1] ? r1 : r0_q;
  assign c_sel  = k_q[0] ? c1 : c0_q;
  assign rd_addr = {RW'(r_sel), CW'(c_sel)};
  assign wr_addr = {RW'(req_i.row), CW'(req_i.column)};

  assign mem_we = accept && (req_i.operation == OP_WRITE) &&
                  (32'(req_i.row) < MAX_ROWS) && (32'(req_i.column) < MAX_COLS);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= {req_i.red_in, req_i.green_in, req_i.blue_in};
    end else if (mem_re) begin
      mem_rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      ch_q         <= '0;
      rd_pend_q    <= 1'b0;
      valid_q      <= 1'b0;
      tex_height_q <= DIM_W'(256);
      tex_width_q  <= DIM_W'(256);
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      ch_q      <= ch_d;
      rd_pend_q <= mem_re;
      valid_q   <= last_step;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEIGHT: tex_height_q <= cfg_wdata_i;
          CFG_WIDTH:  tex_width_q  <= cfg_wdata_i;
          default:    tex_height_q <= tex_height_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= k_q;
    if (rd_pend_q) begin
      tex_q[rd_idx_q] <= mem_rdata_q;
    end
    case (state_q)
      ST_IDLE: begin
        r0_q <= prod[FRAC_BITS +: DIM_W];
        fu_q <= prod[FRAC_BITS-1:0];
        v_q  <= req_i.v_frac;
      end
      ST_COORD: begin
        c0_q <= prod[FRAC_BITS +: DIM_W];
        fv_q <= prod[FRAC_BITS-1:0];
      end
      ST_FETCH: begin
        wt_q[k_q] <= prod[WT_W-1:0];
      end
      ST_BLEND: begin
        acc_q <= acc_sum;
        if (k_q == 2'd3) begin
          case (ch_q)
            2'd0:    red_q   <= acc_sum[OUT_SHIFT +: OUT_W];
            2'd1:    green_q <= acc_sum[OUT_SHIFT +: OUT_W];
            default: rsp_q   <= '{red_out:   red_q,
                                  green_out: green_q,
                                  blue_out:  acc_sum[OUT_SHIFT +: OUT_W]};
          endcase
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== hdl/bts_checker.sv =====
`timescale 1ns / 1ps

module bts_checker
  import bts_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_i,
  input logic     valid_i,
  input bts_req_t req_i
);

  // A sample takes many cycles, so two results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |=> !valid_i)
    else $error("result strobe held for more than one cycle");

  // A result closes a sample: the block was busy just before and is free now.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (!busy_i && $past(busy_i)))
    else $error("result strobe outside the end of a sample");

  // A texel write finishes in the cycle it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && req_i.operation == OP_WRITE) |=> (!busy_i && !valid_i))
    else $error("write transaction occupied the block");

  // An accepted sample occupies the block right away.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && req_i.operation == OP_SAMPLE) |=> busy_i)
    else $error("sample transaction did not raise busy");

endmodule

bind bilinear_texture_sampler_wrap bts_checker u_bts_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .valid_i (valid_o),
  .req_i   (req_i)
);
